@@ rtl/core/wufr_pkg.sv @@
`timescale 1ns / 1ps

package wufr_pkg;

	// Fixed widths of the item fields and configuration registers.
	localparam int OP_W    = 2;
	localparam int NODE_W  = 10;
	localparam int DEPTH_W = 10;
	localparam int CFG_W   = 11;

	localparam logic [CFG_W-1:0] ACTIVE_RST   = 11'd1024;
	localparam logic [CFG_W-1:0] WEIGHTED_RST = 11'd0;

	typedef enum logic [OP_W-1:0] {
		OP_INIT     = 2'd0,
		OP_MERGE    = 2'd1,
		OP_ROLLBACK = 2'd2,
		OP_QUERY    = 2'd3
	} opcode_t;

	localparam logic CFG_ACTIVE   = 1'b0;
	localparam logic CFG_WEIGHTED = 1'b1;

	typedef enum logic [12:0] {
		S_CLEAR    = 13'b0000000000001,
		S_IDLE     = 13'b0000000000010,
		S_FINDA    = 13'b0000000000100,
		S_FINDB    = 13'b0000000001000,
		S_JOIN     = 13'b0000000010000,
		S_WR_HUNG  = 13'b0000000100000,
		S_WR_KEEP  = 13'b0000001000000,
		S_POP_RD   = 13'b0000010000000,
		S_POP_KEEP = 13'b0000100000000,
		S_POP_HUNG = 13'b0001000000000,
		S_START0   = 13'b0010000000000,
		S_FIND0    = 13'b0100000000000,
		S_DONE     = 13'b1000000000000
	} state_t;

endpackage

@@ rtl/core/wufr_ram.sv @@
`timescale 1ns / 1ps

module wufr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/weighted_union_find_rollback.sv @@
`timescale 1ns / 1ps

// Disjoint-set table with union by size and an undo stack of merges.
// Input channel: in_valid / in_stall carry opcode, node_a, node_b and target_depth.
// Output channel: out_valid / out_stall carry stack_depth, merged, all_weight_joined.
// Every item gives exactly one result item. The block takes one item at a time and
// holds in_stall high until that item's result sits in the output register.
// The single read port of the node table paces each item: a root search follows
// the parent chain one hop per cycle, at most log2(NODES) hops under union by size.
// Every item ends with a root search from node 0; a merge first searches both roots
// and writes two entries if they differ; a rollback rewrites two per pop; init sweeps.
// After reset the block sweeps the whole node table, making every node
// its own root with size one and weight zero, and accepts no item meanwhile;
// configuration writes are taken at any time.
// A finished result waits in the output register while out_stall is high; the next
// item may be accepted meanwhile and is held just before its own result is loaded.
module weighted_union_find_rollback
	import wufr_pkg::*;
#(
	parameter int NODES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    opcode,
	input  logic [NODE_W-1:0]  node_a,
	input  logic [NODE_W-1:0]  node_b,
	input  logic [NODE_W-1:0]  target_depth,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DEPTH_W-1:0] stack_depth,
	output logic               merged,
	output logic               all_weight_joined,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	localparam int NW     = $clog2(NODES);
	localparam int CW     = $clog2(NODES + 1);
	localparam int XW     = (NW > CFG_W) ? NW + 1 : CFG_W + 1;
	localparam int UDEPTH = NODES - 1;
	localparam int UAW    = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
	localparam int RW     = NW + 2 * CW;
	localparam int UW     = 2 * NW + 4 * CW;

	state_t state_q;
	opcode_t op_in;

	logic [NW-1:0]     cnt_q, cur_q, depth_q, depth_m1;
	logic              sweep_w_q;
	logic [NODE_W-1:0] b_q, target_q;
	logic [NW-1:0]     ra_q, rb_q;
	logic [CW-1:0]     size_a_q, sum_a_q, size_b_q, sum_b_q;
	logic              swap_q, merged_q, allw_q;
	logic [CFG_W-1:0]  active_q, weighted_q;

	logic               out_valid_q, merged_out_q, allw_out_q;
	logic [DEPTH_W-1:0] stack_depth_q;

	logic            t_we, t_re;
	logic [NW-1:0]   t_waddr, t_raddr;
	logic [RW-1:0]   t_wdata, t_rdata;
	logic            u_we, u_re;
	logic [UAW-1:0]  u_waddr, u_raddr;
	logic [UW-1:0]   u_wdata, u_rdata;

	logic [NW-1:0] rd_parent;
	logic [CW-1:0] rd_size, rd_sum;
	logic          hop_done, accept, merge_ok, sweep_bit, load_out;

	logic [NW-1:0] keep_node, hung_node;
	logic [CW-1:0] size_keep, size_hung, sum_keep, sum_hung;

	logic [NW-1:0] uk_node, uh_node;
	logic [CW-1:0] uk_size, uh_size, uk_sum, uh_sum;

	assign op_in     = opcode_t'(opcode);
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign depth_m1  = depth_q - NW'(1);

	assign rd_parent = t_rdata[RW-1 -: NW];
	assign rd_size   = t_rdata[2*CW-1 -: CW];
	assign rd_sum    = t_rdata[CW-1:0];
	assign hop_done  = (rd_parent == cur_q);

	// A merge that names a node outside the active range, or finds the stack full,
	// is dropped without a search for its two roots.
	assign merge_ok = (XW'(node_a) < XW'(active_q)) && (XW'(node_a) < XW'(NODES))
		&& (XW'(node_b) < XW'(active_q)) && (XW'(node_b) < XW'(NODES))
		&& (depth_q < NW'(NODES - 1));

	assign sweep_bit = sweep_w_q && (XW'(cnt_q) < XW'(weighted_q));

	assign keep_node = swap_q ? rb_q : ra_q;
	assign hung_node = swap_q ? ra_q : rb_q;
	assign size_keep = swap_q ? size_b_q : size_a_q;
	assign size_hung = swap_q ? size_a_q : size_b_q;
	assign sum_keep  = swap_q ? sum_b_q : sum_a_q;
	assign sum_hung  = swap_q ? sum_a_q : sum_b_q;

	assign uk_node = u_rdata[UW-1 -: NW];
	assign uh_node = u_rdata[UW-NW-1 -: NW];
	assign uk_size = u_rdata[4*CW-1 -: CW];
	assign uh_size = u_rdata[3*CW-1 -: CW];
	assign uk_sum  = u_rdata[2*CW-1 -: CW];
	assign uh_sum  = u_rdata[CW-1:0];

	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		t_we    = 1'b0;
		t_waddr = cnt_q;
		t_wdata = '0;
		t_re    = 1'b0;
		t_raddr = rd_parent;
		u_we    = 1'b0;
		u_waddr = depth_q[UAW-1:0];
		u_wdata = {keep_node, hung_node, size_keep, size_hung, sum_keep, sum_hung};
		u_re    = 1'b0;
		u_raddr = depth_m1[UAW-1:0];
		case (state_q)
			S_CLEAR: begin
				t_we    = 1'b1;
				t_wdata = {cnt_q, CW'(1), {{(CW-1){1'b0}}, sweep_bit}};
			end
			S_IDLE: begin
				t_re    = accept && (op_in == OP_MERGE) && merge_ok;
				t_raddr = NW'(node_a);
			end
			S_FINDA: begin
				t_re    = 1'b1;
				t_raddr = hop_done ? NW'(b_q) : rd_parent;
			end
			S_FINDB, S_FIND0: begin
				t_re = !hop_done;
			end
			S_WR_HUNG: begin
				t_we    = 1'b1;
				t_waddr = hung_node;
				t_wdata = {keep_node, size_hung, sum_hung};
				u_we    = 1'b1;
			end
			S_WR_KEEP: begin
				t_we    = 1'b1;
				t_waddr = keep_node;
				t_wdata = {keep_node, CW'(size_keep + size_hung), CW'(sum_keep + sum_hung)};
			end
			S_POP_RD: begin
				u_re = 1'b1;
			end
			S_POP_KEEP: begin
				t_we    = 1'b1;
				t_waddr = uk_node;
				t_wdata = {uk_node, uk_size, uk_sum};
			end
			S_POP_HUNG: begin
				t_we    = 1'b1;
				t_waddr = uh_node;
				t_wdata = {uh_node, uh_size, uh_sum};
			end
			S_START0: begin
				t_re    = 1'b1;
				t_raddr = '0;
			end
			default: begin
				t_re = 1'b0;
			end
		endcase
	end

	wufr_ram #(.WIDTH(RW), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	wufr_ram #(.WIDTH(UW), .DEPTH(UDEPTH)) u_undo_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.re    (u_re),
		.raddr (u_raddr),
		.rdata (u_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			sweep_w_q   <= 1'b0;
			depth_q     <= '0;
			merged_q    <= 1'b0;
			active_q    <= ACTIVE_RST;
			weighted_q  <= WEIGHTED_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACTIVE:   active_q   <= cfg_wdata;
					CFG_WEIGHTED: weighted_q <= cfg_wdata;
					default:      active_q   <= active_q;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(NODES - 1)) begin
						state_q <= sweep_w_q ? S_START0 : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						merged_q <= 1'b0;
						case (op_in)
							OP_INIT: begin
								cnt_q     <= '0;
								sweep_w_q <= 1'b1;
								depth_q   <= '0;
								state_q   <= S_CLEAR;
							end
							OP_MERGE: begin
								state_q <= merge_ok ? S_FINDA : S_START0;
							end
							OP_ROLLBACK: begin
								state_q <= (XW'(depth_q) > XW'(target_depth)) ? S_POP_RD
									: S_START0;
							end
							default: begin
								state_q <= S_START0;
							end
						endcase
					end
				end
				S_FINDA: begin
					if (hop_done) begin
						state_q <= S_FINDB;
					end
				end
				S_FINDB: begin
					if (hop_done) begin
						state_q <= S_JOIN;
					end
				end
				S_JOIN: begin
					state_q <= (ra_q == rb_q) ? S_START0 : S_WR_HUNG;
				end
				S_WR_HUNG: begin
					state_q <= S_WR_KEEP;
				end
				S_WR_KEEP: begin
					depth_q  <= depth_q + NW'(1);
					merged_q <= 1'b1;
					state_q  <= S_START0;
				end
				S_POP_RD: begin
					depth_q <= depth_m1;
					state_q <= S_POP_KEEP;
				end
				S_POP_KEEP: begin
					state_q <= S_POP_HUNG;
				end
				S_POP_HUNG: begin
					state_q <= (XW'(depth_q) > XW'(target_q)) ? S_POP_RD : S_START0;
				end
				S_START0: begin
					state_q <= S_FIND0;
				end
				S_FIND0: begin
					if (hop_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: the search pointer follows the parent chain one hop a cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q    <= NW'(node_a);
				b_q      <= node_b;
				target_q <= target_depth;
			end
			S_FINDA: begin
				if (hop_done) begin
					ra_q     <= cur_q;
					size_a_q <= rd_size;
					sum_a_q  <= rd_sum;
					cur_q    <= NW'(b_q);
				end else begin
					cur_q <= rd_parent;
				end
			end
			S_FINDB: begin
				if (hop_done) begin
					rb_q     <= cur_q;
					size_b_q <= rd_size;
					sum_b_q  <= rd_sum;
				end else begin
					cur_q <= rd_parent;
				end
			end
			S_JOIN: begin
				swap_q <= (size_a_q < size_b_q);
			end
			S_START0: begin
				cur_q <= '0;
			end
			S_FIND0: begin
				if (hop_done) begin
					allw_q <= (XW'(rd_sum) == XW'(weighted_q));
				end else begin
					cur_q <= rd_parent;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
		if (load_out) begin
			stack_depth_q <= DEPTH_W'(depth_q);
			merged_out_q  <= merged_q;
			allw_out_q    <= allw_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign stack_depth       = stack_depth_q;
	assign merged            = merged_out_q;
	assign all_weight_joined = allw_out_q;

	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR_KEEP) |=> (depth_q == $past(depth_q) + NW'(1)))
		else $error("merge did not raise the stack depth by one");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_RD) |-> (depth_q != '0))
		else $error("pop started on an empty undo stack");

	a_join_size: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_JOIN) && (ra_q != rb_q))
		|-> (({1'b0, size_a_q} + {1'b0, size_b_q}) <= (CW+1)'(NODES)))
		else $error("two distinct roots hold more nodes than the table");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block took a second item before finishing the first");

endmodule

@@ bench/tb_weighted_union_find_rollback.sv @@
`timescale 1ns / 1ps

module tb_weighted_union_find_rollback;
	import wufr_pkg::*;

	localparam int NODES      = 1024;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_PHASES   = 10;

	// Random phases: active nodes, weighted nodes, item count.
	localparam int PH_ACT [N_PHASES] = '{8, 16, 1024, 2, 1024, 64, 3, 1, 32, 1024};
	localparam int PH_WGT [N_PHASES] = '{8, 5, 0, 1, 1024, 40, 3, 0, 33, 600};
	localparam int PH_CNT [N_PHASES] = '{200, 200, 150, 100, 150, 250, 100, 50, 200, 200};
	localparam int CALM_PHASE = 5;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               merged;
		logic               all_joined;
	} outcome_t;

	typedef struct packed {
		logic [NODE_W-1:0] keep;
		logic [NODE_W-1:0] hung;
		logic [CFG_W-1:0]  size_keep;
		logic [CFG_W-1:0]  size_hung;
		logic [CFG_W-1:0]  sum_keep;
		logic [CFG_W-1:0]  sum_hung;
	} undo_t;

	typedef struct {
		bit                reconf;
		int unsigned       act;
		int unsigned       wgt;
		opcode_t           op;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [NODE_W-1:0] tgt;
		bit                typed;
		outcome_t          want;
	} probe_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [OP_W-1:0]    opcode       = OP_QUERY;
	logic [NODE_W-1:0]  node_a       = '0;
	logic [NODE_W-1:0]  node_b       = '0;
	logic [NODE_W-1:0]  target_depth = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [DEPTH_W-1:0] stack_depth;
	logic               merged;
	logic               all_weight_joined;
	logic               cfg_we       = 1'b0;
	logic               cfg_index    = CFG_ACTIVE;
	logic [CFG_W-1:0]   cfg_wdata    = '0;

	// Local copy of the disjoint-set table, undo log and registers.
	logic [NODE_W-1:0] uf_parent [NODES];
	logic [CFG_W-1:0]  uf_size [NODES];
	logic [CFG_W-1:0]  uf_wsum [NODES];
	undo_t             undo_log [NODES-1];
	int unsigned       log_depth;
	logic [CFG_W-1:0]  cfg_active;
	logic [CFG_W-1:0]  cfg_weighted;

	outcome_t outcome_q [$];
	int       mismatch_count = 0;
	int       quiet_cycles   = 0;
	bit       no_gaps        = 1'b0;

	weighted_union_find_rollback #(.NODES(NODES)) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.opcode            (opcode),
		.node_a            (node_a),
		.node_b            (node_b),
		.target_depth      (target_depth),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.stack_depth       (stack_depth),
		.merged            (merged),
		.all_weight_joined (all_weight_joined),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] v);
		int hops;
		hops = 0;
		while (uf_parent[v] != v && hops < NODES) begin
			v = uf_parent[v];
			hops++;
		end
		return v;
	endfunction

	function automatic outcome_t predict_step(input opcode_t op,
			input logic [NODE_W-1:0] a, b, tgt);
		int                lim;
		logic [NODE_W-1:0] ra;
		logic [NODE_W-1:0] rb;
		logic [NODE_W-1:0] tmp;
		undo_t             rec;
		outcome_t          res;
		bit                joined;
		joined = 1'b0;
		case (op)
			OP_INIT: begin
				for (int i = 0; i < NODES; i++) begin
					uf_parent[i] = NODE_W'(i);
					uf_size[i]   = 11'd1;
					uf_wsum[i]   = (i < cfg_weighted) ? 11'd1 : 11'd0;
				end
				log_depth = 0;
			end
			OP_MERGE: begin
				lim = (cfg_active < NODES) ? int'(cfg_active) : NODES;
				if (a < lim && b < lim && log_depth < NODES - 1) begin
					ra = root_of(a);
					rb = root_of(b);
					if (ra != rb) begin
						// The larger set keeps its root; a tie keeps node_a's root.
						if (uf_size[ra] < uf_size[rb]) begin
							tmp = ra;
							ra  = rb;
							rb  = tmp;
						end
						undo_log[log_depth] = '{ra, rb, uf_size[ra], uf_size[rb],
							uf_wsum[ra], uf_wsum[rb]};
						log_depth++;
						uf_size[ra]   = uf_size[ra] + uf_size[rb];
						uf_wsum[ra]   = uf_wsum[ra] + uf_wsum[rb];
						uf_parent[rb] = ra;
						joined        = 1'b1;
					end
				end
			end
			OP_ROLLBACK: begin
				while (log_depth > tgt) begin
					log_depth--;
					rec = undo_log[log_depth];
					uf_parent[rec.keep] = rec.keep;
					uf_parent[rec.hung] = rec.hung;
					uf_size[rec.keep]   = rec.size_keep;
					uf_size[rec.hung]   = rec.size_hung;
					uf_wsum[rec.keep]   = rec.sum_keep;
					uf_wsum[rec.hung]   = rec.sum_hung;
				end
			end
			default: ;
		endcase
		res.depth      = log_depth[DEPTH_W-1:0];
		res.merged     = joined;
		res.all_joined = (uf_wsum[root_of('0)] == cfg_weighted);
		return res;
	endfunction

	function automatic probe_row_t probe(input bit reconf, input int unsigned act, wgt,
			input opcode_t op, input int unsigned a, b, tgt,
			input bit typed, input int unsigned d, input bit m, j);
		probe_row_t r;
		r.reconf = reconf;
		r.act    = act;
		r.wgt    = wgt;
		r.op     = op;
		r.a      = NODE_W'(a);
		r.b      = NODE_W'(b);
		r.tgt    = NODE_W'(tgt);
		r.typed  = typed;
		r.want   = '{DEPTH_W'(d), m, j};
		return r;
	endfunction

	task automatic send_item(input opcode_t op, input logic [NODE_W-1:0] a, b, tgt,
			input bit typed, input outcome_t want);
		outcome_t got;
		while (!no_gaps && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		node_a       <= a;
		node_b       <= b;
		target_depth <= tgt;
		do @(posedge clk); while (in_stall);
		got = predict_step(op, a, b, tgt);
		outcome_q = {outcome_q, (typed ? want : got)};
	endtask

	// Holds the sender off until every pending result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outcome_q.size() != 0);
	endtask

	task automatic set_config(input int unsigned act, wgt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ACTIVE;
		cfg_wdata <= CFG_W'(act);
		@(posedge clk);
		cfg_index <= CFG_WEIGHTED;
		cfg_wdata <= CFG_W'(wgt);
		@(posedge clk);
		cfg_we       <= 1'b0;
		cfg_active   = CFG_W'(act);
		cfg_weighted = CFG_W'(wgt);
	endtask

	always @(posedge clk) begin
		outcome_t want;
		out_stall <= !no_gaps && ($urandom_range(99) < 21);
		if (arst_n && out_valid && !out_stall) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result: depth %0d merged %0d joined %0d",
					$time, stack_depth, merged, all_weight_joined);
				mismatch_count++;
			end else begin
				want = outcome_q.pop_front();
				if (stack_depth !== want.depth) begin
					$display("%0t: stack_depth expected %0d, actual %0d",
						$time, want.depth, stack_depth);
					mismatch_count++;
				end
				if (merged !== want.merged) begin
					$display("%0t: merged expected %0d, actual %0d",
						$time, want.merged, merged);
					mismatch_count++;
				end
				if (all_weight_joined !== want.all_joined) begin
					$display("%0t: all_weight_joined expected %0d, actual %0d",
						$time, want.all_joined, all_weight_joined);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		probe_row_t        dir_q [$];
		outcome_t          none;
		opcode_t           op;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [NODE_W-1:0] tgt;
		int                roll;
		int                act;

		none = '0;
		// Reset leaves the same table as an init with no weighted nodes.
		cfg_active   = ACTIVE_RST;
		cfg_weighted = WEIGHTED_RST;
		void'(predict_step(OP_INIT, '0, '0, '0));

		// Reset settings: extremes of the node range, same-set merge, no-op rollback.
		dir_q = {dir_q, probe(0, 0, 0, OP_QUERY, 0, 0, 0, 1, 0, 0, 1)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 0, 1, 0, 1, 1, 1, 1)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 1023, 1022, 0, 1, 2, 1, 1)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 0, 1, 0, 1, 2, 0, 1)};
		dir_q = {dir_q, probe(0, 0, 0, OP_ROLLBACK, 0, 0, 1023, 1, 2, 0, 1)};
		dir_q = {dir_q, probe(0, 0, 0, OP_ROLLBACK, 0, 0, 0, 1, 0, 0, 1)};
		dir_q = {dir_q, probe(0, 0, 0, OP_INIT, 0, 0, 0, 1, 0, 0, 1)};
		// Four active nodes, all weighted; merges naming inactive nodes are ignored.
		dir_q = {dir_q, probe(1, 4, 4, OP_INIT, 0, 0, 0, 1, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 0, 1, 0, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 2, 3, 0, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 1, 3, 0, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 0, 4, 0, 1, 3, 0, 1)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 1023, 0, 0, 1, 3, 0, 1)};
		dir_q = {dir_q, probe(0, 0, 0, OP_QUERY, 0, 0, 0, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_ROLLBACK, 0, 0, 2, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_ROLLBACK, 0, 0, 0, 1, 0, 0, 0)};
		// A single active node with every node of the table weighted.
		dir_q = {dir_q, probe(1, 1, 1024, OP_INIT, 0, 0, 0, 1, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 0, 0, 0, 1, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 0, 1, 0, 1, 0, 0, 0)};
		dir_q = {dir_q, probe(1, 1024, 1024, OP_INIT, 0, 0, 0, 1, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 'h2AA, 'h155, 0, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_ROLLBACK, 0, 0, 'h3FF, 0, 0, 0, 0)};
		// Weight given to nodes beyond the active range can never be joined.
		dir_q = {dir_q, probe(1, 4, 8, OP_INIT, 0, 0, 0, 1, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 0, 1, 0, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 2, 3, 0, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_MERGE, 3, 0, 0, 0, 0, 0, 0)};
		dir_q = {dir_q, probe(0, 0, 0, OP_QUERY, 0, 0, 0, 0, 0, 0, 0)};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_q[i]) begin
			if (dir_q[i].reconf) begin
				drain();
				set_config(dir_q[i].act, dir_q[i].wgt);
			end
			send_item(dir_q[i].op, dir_q[i].a, dir_q[i].b, dir_q[i].tgt,
				dir_q[i].typed, dir_q[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			no_gaps = (p == CALM_PHASE);
			set_config(PH_ACT[p], PH_WGT[p]);
			act = PH_ACT[p];
			send_item(OP_INIT, '0, '0, '0, 1'b0, none);
			for (int k = 1; k < PH_CNT[p]; k++) begin
				roll = $urandom_range(99);
				op   = OP_QUERY;
				a    = NODE_W'($urandom_range(1023));
				b    = NODE_W'($urandom_range(1023));
				tgt  = NODE_W'($urandom_range(1023));
				if (roll < 55) begin
					op = OP_MERGE;
					a  = NODE_W'($urandom_range(act - 1));
					b  = NODE_W'($urandom_range(act - 1));
				end else if (roll < 70) begin
					op  = OP_ROLLBACK;
					tgt = (log_depth == 0) ? '0 : NODE_W'($urandom_range(log_depth - 1));
				end else if (roll < 74) begin
					op = OP_ROLLBACK;
				end else if (roll < 84) begin
					op = OP_QUERY;
				end else if (roll < 88) begin
					op = OP_INIT;
				end else begin
					// Noise: any operation with unconstrained fields.
					op = opcode_t'($urandom_range(3));
				end
				send_item(op, a, b, tgt, 1'b0, none);
				if ($urandom_range(99) == 0)
					drain();
			end
		end
		drain();
		no_gaps = 1'b0;
		repeat (100) @(posedge clk);

		if (mismatch_count == 0 && outcome_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/wufr_pkg.sv
rtl/core/wufr_ram.sv
rtl/core/weighted_union_find_rollback.sv
bench/tb_weighted_union_find_rollback.sv
